### rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, codes and constants for the UV sphere grid point generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int MAX_RINGS_DEF    = 256;

    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_SEGMENTS = 2'd1;
    localparam logic [1:0] REG_RINGS    = 2'd2;

    localparam logic [15:0] RADIUS_RST   = 16'd512;
    localparam logic [8:0]  SEGMENTS_RST = 9'd8;
    localparam logic [8:0]  RINGS_RST    = 9'd8;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_TRI    = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // sin/cos unit: phase fold, square, 12-stage series, output fold
    localparam int TRIG_LAT = 15;
    // front stage, 16 divider stages, trig, product, output scaling
    localparam int DIV_BITS = 16;
    localparam int PIPE_LEN = 1 + DIV_BITS + TRIG_LAT + 2;

    typedef struct packed {
        logic [8:0] ring;
        logic [7:0] segment;
    } in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        corner_a;
        logic [16:0]        corner_b;
        logic [16:0]        corner_c;
        logic               last;
    } out_t;

    typedef struct packed {
        logic        err;
        logic        last_ring;
        logic [17:0] base;
        logic [7:0]  seg;
    } side_t;

    // Series divisors: steps 0..2 sine chain, steps 3..6 cosine chain
    function automatic int step_divisor(input int k);
        int d;
        d = 2;
        case (k)
            0: d = 42;
            1: d = 20;
            2: d = 6;
            3: d = 56;
            4: d = 30;
            5: d = 12;
            default: d = 2;
        endcase
        return d;
    endfunction

endpackage

### rtl/uvs_trig.sv
// ----------------------------------------------------------------------------
// uvs_trig
// Pipelined sine/cosine of a 16-bit turn phase, Q30 results, Taylor series.
// ----------------------------------------------------------------------------
module uvs_trig (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    localparam int NSTEP     = 7;
    localparam int SIN_LAST  = 2;
    localparam int COS_FIRST = 3;
    localparam int X_DLY     = 9;
    localparam int Q_DLY     = 12;

    localparam logic [30:0] HALF_PI_Q30_L = uvs_pkg::HALF_PI_Q30;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [29:0] x1_reg;
    logic [1:0]  quad1_reg;
    logic        swap1_reg;
    logic [29:0] x2_reg;
    logic [29:0] x2x_reg;
    logic [1:0]  quad2_reg;
    logic        swap2_reg;

    logic [29:0] xd_reg [X_DLY];
    logic [1:0]  qd_reg [Q_DLY];
    logic        sd_reg [Q_DLY];

    logic [29:0] pa_reg  [NSTEP];
    logic [29:0] x2a_reg [NSTEP];
    logic [29:0] pb_reg  [NSTEP];
    logic [29:0] qe_reg  [NSTEP];
    logic [29:0] x2b_reg [NSTEP];
    logic [30:0] t_reg   [NSTEP];
    logic [29:0] x2c_reg [NSTEP];

    logic [30:0] sfin_reg;
    logic [30:0] sd1_reg;
    logic [30:0] sd2_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    logic [13:0] f;
    logic        swap;
    logic [13:0] g;
    logic [44:0] xprod;

    always_comb
    begin
        f     = phase[13:0];
        swap  = f > 14'd8192;
        g     = swap ? 14'(15'd16384 - {1'b0, f}) : f;
        xprod = 45'(g) * 45'(HALF_PI_Q30_L) + 45'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= 30'(xprod >> 14);
            quad1_reg <= phase[15:14];
            swap1_reg <= swap;
            x2_reg    <= 30'((60'(x1_reg) * 60'(x1_reg)) >> 30);
            x2x_reg   <= x1_reg;
            quad2_reg <= quad1_reg;
            swap2_reg <= swap1_reg;
            xd_reg[0] <= x2x_reg;
            qd_reg[0] <= quad2_reg;
            sd_reg[0] <= swap2_reg;
            for (int i = 1; i < X_DLY; i++)
            begin
                xd_reg[i] <= xd_reg[i-1];
            end
            for (int i = 1; i < Q_DLY; i++)
            begin
                qd_reg[i] <= qd_reg[i-1];
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        localparam int          DIV    = uvs_pkg::step_divisor(k);
        localparam logic [29:0] RECIP  = 30'((64'd1 << 30) / DIV);
        localparam bit          FIRST  = (k == 0) || (k == COS_FIRST);

        logic [30:0] t_in;
        logic [29:0] x2_in;
        logic [29:0] r;
        logic [29:0] q;

        if (FIRST)
        begin : g_first
            assign t_in  = uvs_pkg::Q30_ONE;
            assign x2_in = x2_reg;
        end
        else
        begin : g_next
            assign t_in  = t_reg[k-1];
            assign x2_in = x2c_reg[k-1];
        end

        always_comb
        begin
            r = pb_reg[k] - 30'(36'(qe_reg[k]) * 36'(DIV));
            q = (r >= 30'(DIV)) ? qe_reg[k] + 30'd1 : qe_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_reg[k]  <= 30'((61'(x2_in) * 61'(t_in)) >> 30);
                x2a_reg[k] <= x2_in;
                qe_reg[k]  <= 30'((60'(pa_reg[k]) * 60'(RECIP)) >> 30);
                pb_reg[k]  <= pa_reg[k];
                x2b_reg[k] <= x2a_reg[k];
                t_reg[k]   <= uvs_pkg::Q30_ONE - 31'(q);
                x2c_reg[k] <= x2b_reg[k];
            end
        end
    end

    logic [30:0] s_m;
    logic [30:0] c_m;
    logic signed [31:0] s_pos;
    logic signed [31:0] c_pos;
    logic signed [31:0] s_out;
    logic signed [31:0] c_out;

    always_comb
    begin
        s_m   = sd_reg[Q_DLY-1] ? t_reg[NSTEP-1] : sd2_reg;
        c_m   = sd_reg[Q_DLY-1] ? sd2_reg : t_reg[NSTEP-1];
        s_pos = $signed({1'b0, s_m});
        c_pos = $signed({1'b0, c_m});
        case (qd_reg[Q_DLY-1])
            QUAD_0:
            begin
                s_out = s_pos;
                c_out = c_pos;
            end
            QUAD_1:
            begin
                s_out = c_pos;
                c_out = -s_pos;
            end
            QUAD_2:
            begin
                s_out = -s_pos;
                c_out = -c_pos;
            end
            default:
            begin
                s_out = -c_pos;
                c_out = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sfin_reg <= 31'((61'(xd_reg[X_DLY-1]) * 61'(t_reg[SIN_LAST])) >> 30);
            sd1_reg  <= sfin_reg;
            sd2_reg  <= sd1_reg;
            sin_reg  <= s_out;
            cos_reg  <= c_out;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

### rtl/uv_sphere_vertex_and_triangle_gen_top.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_triangle_gen_top
// UV sphere grid point to vertex, normal and triangle index generator.
// ----------------------------------------------------------------------------
// A grid point (ring, segment) is taken on every cycle the pipeline is not
// backed up and goes through a 16-stage radix-2 divider forming both angle
// phases, a 15-stage sine/cosine unit evaluating them, then one product and
// one scaling stage. Results leave on a single channel: one transaction for
// an error or a last-ring point, three (vertex, two triangles) otherwise; a
// new point loads only once the previous point's last transaction is taken.
// Registers must be written over APB only while no transaction is in flight;
// the block does not enforce this; radius 0x0, segments_around 0x4, ring_count 0x8.
module uv_sphere_vertex_and_triangle_gen_top #(
    parameter int MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int MAX_RINGS    = uvs_pkg::MAX_RINGS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  uvs_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output uvs_pkg::out_t                 out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uvs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NST = uvs_pkg::PIPE_LEN;
    localparam int ND  = uvs_pkg::DIV_BITS;

    localparam logic [1:0] BEAT_VERT  = 2'd0;
    localparam logic [1:0] BEAT_TRI_A = 2'd1;
    localparam logic [1:0] BEAT_TRI_B = 2'd2;

    // ---------------- configuration ----------------
    logic [15:0] radius_reg;
    logic [8:0]  segs_reg;
    logic [8:0]  rings_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= uvs_pkg::RADIUS_RST;
            segs_reg   <= uvs_pkg::SEGMENTS_RST;
            rings_reg  <= uvs_pkg::RINGS_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                uvs_pkg::REG_RADIUS:   radius_reg <= pwdata[15:0];
                uvs_pkg::REG_SEGMENTS: segs_reg   <= pwdata[8:0];
                uvs_pkg::REG_RINGS:    rings_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            uvs_pkg::REG_RADIUS:   prdata = {16'd0, radius_reg};
            uvs_pkg::REG_SEGMENTS: prdata = {23'd0, segs_reg};
            uvs_pkg::REG_RINGS:    prdata = {23'd0, rings_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic               adv;
    logic               ser_free;
    logic               v_reg    [NST];
    uvs_pkg::side_t     side_reg [NST];
    uvs_pkg::side_t     side_in;
    logic               bad_cfg;

    assign adv      = !v_reg[NST-1] || ser_free;
    assign in_ready = adv;

    always_comb
    begin
        bad_cfg = (segs_reg == 9'd0) || (int'(segs_reg) > MAX_SEGMENTS) ||
                  (rings_reg == 9'd0) || (int'(rings_reg) > MAX_RINGS);
        side_in.err       = bad_cfg || (in_data.ring > rings_reg) ||
                            ({1'b0, in_data.segment} >= segs_reg);
        side_in.last_ring = in_data.ring == rings_reg;
        side_in.base      = 18'(in_data.ring) * 18'(segs_reg);
        side_in.seg       = in_data.segment;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NST; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- phase divider ----------------
    // polar: (ring*65536 + rings) / (2*rings); azimuth: (seg*131072 + segs) / (2*segs)
    logic [26:0] rp_reg [ND+1];
    logic [26:0] ro_reg [ND+1];
    logic [15:0] qp_reg [ND+1];
    logic [15:0] qo_reg [ND+1];
    logic [9:0]  dp;
    logic [9:0]  dq;

    assign dp = {rings_reg, 1'b0};
    assign dq = {segs_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg[0] <= 27'({in_data.ring, 16'd0}) + 27'(rings_reg);
            ro_reg[0] <= 27'({in_data.segment, 17'd0}) + 27'(segs_reg);
            qp_reg[0] <= 16'd0;
            qo_reg[0] <= 16'd0;
        end
    end

    for (genvar d = 1; d <= ND; d++)
    begin : g_div
        localparam int BIT = ND - d;
        logic [26:0] sp;
        logic [26:0] so;

        assign sp = 27'(dp) << BIT;
        assign so = 27'(dq) << BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rp_reg[d-1] >= sp)
                begin
                    rp_reg[d] <= rp_reg[d-1] - sp;
                    qp_reg[d] <= qp_reg[d-1] | (16'd1 << BIT);
                end
                else
                begin
                    rp_reg[d] <= rp_reg[d-1];
                    qp_reg[d] <= qp_reg[d-1];
                end
                if (ro_reg[d-1] >= so)
                begin
                    ro_reg[d] <= ro_reg[d-1] - so;
                    qo_reg[d] <= qo_reg[d-1] | (16'd1 << BIT);
                end
                else
                begin
                    ro_reg[d] <= ro_reg[d-1];
                    qo_reg[d] <= qo_reg[d-1];
                end
            end
        end
    end

    // ---------------- sine / cosine ----------------
    logic signed [31:0] sp_q30;
    logic signed [31:0] cp_q30;
    logic signed [31:0] so_q30;
    logic signed [31:0] co_q30;

    uvs_trig u_trig_polar (
        .clk     (clk),
        .en      (adv),
        .phase   (qp_reg[ND]),
        .sin_q30 (sp_q30),
        .cos_q30 (cp_q30)
    );

    uvs_trig u_trig_azim (
        .clk     (clk),
        .en      (adv),
        .phase   (qo_reg[ND]),
        .sin_q30 (so_q30),
        .cos_q30 (co_q30)
    );

    // ---------------- products and scaling ----------------
    function automatic logic [30:0] mag31(input logic signed [31:0] a);
        logic signed [31:0] n;
        n = -a;
        return a[31] ? n[30:0] : a[30:0];
    endfunction

    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [61:0] p;
        logic [31:0] m;
        p = 62'(mag31(a)) * 62'(mag31(b)) + 62'(33'd1 << 29);
        m = 32'(p >> 30);
        return (a[31] != b[31]) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [15:0] to_pos(input logic signed [31:0] u,
                                           input logic [15:0] rad);
        logic [46:0] p;
        logic [16:0] m;
        logic [15:0] v;
        p = 47'(mag31(u)) * 47'(rad) + 47'(33'd1 << 29);
        m = 17'(p >> 30);
        if (u[31])
        begin
            v = (m > 17'd32768) ? 16'h8000 : 16'(-m);
        end
        else
        begin
            v = (m > 17'd32767) ? 16'h7fff : m[15:0];
        end
        return v;
    endfunction

    function automatic logic [15:0] to_q14(input logic signed [31:0] u);
        logic [31:0] s;
        logic [15:0] m;
        s = 32'(mag31(u)) + 32'h8000;
        m = 16'(s >> 16);
        return u[31] ? -m : m;
    endfunction

    logic signed [31:0] ux_reg;
    logic signed [31:0] uy_reg;
    logic signed [31:0] uz_reg;
    logic [15:0] px_reg, py_reg, pz_reg;
    logic [15:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg <= mul_q30(sp_q30, so_q30);
            uy_reg <= cp_q30;
            uz_reg <= mul_q30(sp_q30, co_q30);
            px_reg <= to_pos(ux_reg, radius_reg);
            py_reg <= to_pos(uy_reg, radius_reg);
            pz_reg <= to_pos(uz_reg, radius_reg);
            nx_reg <= to_q14(ux_reg);
            ny_reg <= to_q14(uy_reg);
            nz_reg <= to_q14(uz_reg);
        end
    end

    // ---------------- result serialiser ----------------
    logic        ser_valid_reg;
    logic [1:0]  beat_reg;
    logic        ser_err_reg;
    logic        ser_lr_reg;
    logic [15:0] sx_reg, sy_reg, sz_reg, snx_reg, sny_reg, snz_reg;
    logic [16:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic        ser_load;
    logic        ser_last;

    uvs_pkg::side_t sl;
    logic           wrap;
    logic [18:0]    t0, t1, t2, t3;

    always_comb
    begin
        sl   = side_reg[NST-1];
        wrap = {1'b0, sl.seg} == (segs_reg - 9'd1);
        t0   = 19'(sl.base) + 19'(sl.seg);
        t2   = t0 + 19'(segs_reg);
        t1   = wrap ? 19'(sl.base) : t0 + 19'd1;
        t3   = wrap ? 19'(sl.base) + 19'(segs_reg) : t2 + 19'd1;
    end

    assign ser_last = ser_err_reg || ser_lr_reg || (beat_reg == BEAT_TRI_B);
    assign ser_free = !ser_valid_reg || (out_ready && ser_last);
    assign ser_load = v_reg[NST-1] && ser_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            beat_reg      <= BEAT_VERT;
        end
        else if (ser_load)
        begin
            ser_valid_reg <= 1'b1;
            beat_reg      <= BEAT_VERT;
        end
        else if (ser_valid_reg && out_ready)
        begin
            if (ser_last)
            begin
                ser_valid_reg <= 1'b0;
                beat_reg      <= BEAT_VERT;
            end
            else
            begin
                beat_reg <= beat_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_err_reg <= sl.err;
            ser_lr_reg  <= sl.last_ring;
            sx_reg      <= px_reg;
            sy_reg      <= py_reg;
            sz_reg      <= pz_reg;
            snx_reg     <= nx_reg;
            sny_reg     <= ny_reg;
            snz_reg     <= nz_reg;
            t0_reg      <= t0[16:0];
            t1_reg      <= t1[16:0];
            t2_reg      <= t2[16:0];
            t3_reg      <= t3[16:0];
        end
    end

    logic vert_beat;

    always_comb
    begin
        vert_beat          = !ser_err_reg && (beat_reg == BEAT_VERT);
        out_data.kind      = ser_err_reg ? uvs_pkg::KIND_ERR :
                             (vert_beat ? uvs_pkg::KIND_VERTEX : uvs_pkg::KIND_TRI);
        out_data.pos_x     = vert_beat ? sx_reg  : 16'sd0;
        out_data.pos_y     = vert_beat ? sy_reg  : 16'sd0;
        out_data.pos_z     = vert_beat ? sz_reg  : 16'sd0;
        out_data.norm_x    = vert_beat ? snx_reg : 16'sd0;
        out_data.norm_y    = vert_beat ? sny_reg : 16'sd0;
        out_data.norm_z    = vert_beat ? snz_reg : 16'sd0;
        out_data.corner_a  = 17'd0;
        out_data.corner_b  = 17'd0;
        out_data.corner_c  = 17'd0;
        if (!ser_err_reg && (beat_reg == BEAT_TRI_A))
        begin
            out_data.corner_a = t0_reg;
            out_data.corner_b = t2_reg;
            out_data.corner_c = t1_reg;
        end
        else if (!ser_err_reg && (beat_reg == BEAT_TRI_B))
        begin
            out_data.corner_a = t1_reg;
            out_data.corner_b = t2_reg;
            out_data.corner_c = t3_reg;
        end
        out_data.last      = ser_last;
    end

    assign out_valid = ser_valid_reg;

    // ---------------- assertions ----------------
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == uvs_pkg::KIND_ERR) |-> out_data.last)
        else $error("error transaction not marked last");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && v_reg[NST-1])
        else $error("input stalled without a pending result");

    a_tri_beats: assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg && (beat_reg != BEAT_VERT) |-> !ser_err_reg && !ser_lr_reg)
        else $error("triangle beat on a single-result point");

    a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(beat_reg) && out_valid)
        else $error("result changed while stalled");

endmodule
